FILE: rtl/sid_pkg.sv
`timescale 1ns / 1ps

package sid_pkg;

  localparam int VALUE_BITS_DEF = 32;

  localparam logic [5:0] CH_MINUS = 6'd45;
  localparam logic [5:0] CH_ZERO  = 6'd48;

  // decimal digits needed for a magnitude of up to 2^(bits-1), never fewer
  function automatic int sid_digits(input int bits);
    return (bits * 31) / 100 + 1;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } sid_state_e;

  typedef struct packed {
    logic load;
    logic conv;
    logic dshift;
    logic emit;
    logic sign;
    logic last;
  } sid_ctrl_t;

endpackage

FILE: rtl/sid_bcd_unit.sv
`timescale 1ns / 1ps

module sid_bcd_unit #(
  parameter int VALUE_BITS = sid_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  sid_pkg::sid_ctrl_t    ctrl_i,
  input  logic [VALUE_BITS-1:0] mag_i,
  output logic [3:0]            top_digit_o
);
  import sid_pkg::*;

  localparam int NDIG = sid_digits(VALUE_BITS);
  localparam int BW   = NDIG * 4;

  logic [BW-1:0]         bcd_q, bcd_d;
  logic [BW-1:0]         adj;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [3:0]            dig;

  // add three to every digit of five or more
  always_comb begin
    adj = '0;
    dig = '0;
    for (int k = 0; k < NDIG; k++) begin
      dig = bcd_q[k*4 +: 4];
      adj[k*4 +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  always_comb begin
    bcd_d = bcd_q;
    bin_d = bin_q;
    priority if (ctrl_i.load) begin
      bcd_d = '0;
      bin_d = mag_i;
    end else if (ctrl_i.conv) begin
      bcd_d = {adj[BW-2:0], bin_q[VALUE_BITS-1]};
      bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
    end else if (ctrl_i.dshift) begin
      bcd_d = {bcd_q[BW-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    bin_q <= bin_d;
  end

  assign top_digit_o = bcd_q[BW-1 -: 4];

endmodule

FILE: rtl/sid_seq.sv
`timescale 1ns / 1ps

module sid_seq #(
  parameter int VALUE_BITS = sid_pkg::VALUE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               neg_i,
  input  logic               top_zero_i,
  output logic               busy_o,
  output sid_pkg::sid_ctrl_t ctrl_o
);
  import sid_pkg::*;

  localparam int NDIG = sid_digits(VALUE_BITS);
  localparam int BCW  = $clog2(VALUE_BITS + 1);
  localparam int DCW  = $clog2(NDIG + 1);

  sid_state_e     state_q, state_d;
  logic [BCW-1:0] bit_cnt_q, bit_cnt_d;
  logic [DCW-1:0] dig_cnt_q, dig_cnt_d;
  logic           neg_q, neg_d;
  logic           skipping;
  logic           final_dig;

  assign skipping  = top_zero_i && (dig_cnt_q > DCW'(1));
  assign final_dig = (dig_cnt_q == DCW'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_CONV;
      ST_CONV: begin
        if (bit_cnt_q == BCW'(1)) state_d = neg_q ? ST_SIGN : ST_SKIP;
      end
      ST_SIGN: state_d = ST_SKIP;
      ST_SKIP: begin
        if (!skipping) state_d = final_dig ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: if (final_dig) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      ST_IDLE: ctrl_o.load = start_i;
      ST_CONV: ctrl_o.conv = 1'b1;
      ST_SIGN: begin
        ctrl_o.emit = 1'b1;
        ctrl_o.sign = 1'b1;
      end
      ST_SKIP: begin
        ctrl_o.dshift = 1'b1;
        ctrl_o.emit   = !skipping;
        ctrl_o.last   = !skipping && final_dig;
      end
      ST_EMIT: begin
        ctrl_o.dshift = 1'b1;
        ctrl_o.emit   = 1'b1;
        ctrl_o.last   = final_dig;
      end
      default: ctrl_o = '0;
    endcase
  end

  always_comb begin
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    neg_d     = neg_q;
    if (ctrl_o.load) begin
      bit_cnt_d = BCW'(VALUE_BITS);
      dig_cnt_d = DCW'(NDIG);
      neg_d     = neg_i;
    end
    if (ctrl_o.conv) bit_cnt_d = bit_cnt_q - BCW'(1);
    if (ctrl_o.dshift) dig_cnt_d = dig_cnt_q - DCW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bit_cnt_q <= '0;
      dig_cnt_q <= '0;
      neg_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      dig_cnt_q <= dig_cnt_d;
      neg_q     <= neg_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

FILE: rtl/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps

// Signed integer to decimal ASCII text.
// Input: pulse start_i with value_i while busy_o is low; the value is taken
// at that edge and busy_o rises on the next cycle.
// Output: one character per valid_o pulse on ascii_char_o, most significant
// first, a leading '-' for negative values; last_char_o marks the final
// character of the number. Each transfer lasts exactly one cycle and the
// receiver has no way to hold it off.
// Sequence: the magnitude goes through a shift-and-add-three binary to BCD
// unit, one bit per cycle. Then the sign is sent (negative only) and each
// stored decimal digit (10 at 32 bits) is shifted out in turn, leading zeros
// skipped without a transfer. One number is handled at a time: a new start
// is taken only once busy_o is low again.
// Reset: asynchronous, active low; the block returns idle and no character
// is in flight.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = sid_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         valid_o,
  output logic [5:0]                   ascii_char_o,
  output logic                         last_char_o
);
  import sid_pkg::*;

  sid_ctrl_t             ctrl;
  logic [VALUE_BITS-1:0] vu;
  logic [VALUE_BITS-1:0] mag;
  logic [3:0]            top_digit;
  logic                  valid_q;
  logic [5:0]            char_q, char_d;
  logic                  last_q;

  assign vu  = $unsigned(value_i);
  assign mag = vu[VALUE_BITS-1] ? (~vu + VALUE_BITS'(1)) : vu;

  sid_seq #(
    .VALUE_BITS(VALUE_BITS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .neg_i     (vu[VALUE_BITS-1]),
    .top_zero_i(top_digit == 4'd0),
    .busy_o    (busy_o),
    .ctrl_o    (ctrl)
  );

  sid_bcd_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_bcd (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .mag_i      (mag),
    .top_digit_o(top_digit)
  );

  assign char_d = ctrl.sign ? CH_MINUS : CH_ZERO + {2'b00, top_digit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      char_q <= char_d;
      last_q <= ctrl.last;
    end
  end

  assign valid_o      = valid_q;
  assign ascii_char_o = char_q;
  assign last_char_o  = last_q;

endmodule

FILE: rtl/sid_checker.sv
`timescale 1ns / 1ps

module sid_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       valid_o,
  input logic [5:0] ascii_char_o,
  input logic       last_char_o
);
  import sid_pkg::*;

  // a start transfer always makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("not busy after start transfer");

  // nothing is sent out of an idle cycle
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !valid_o)
    else $error("character after idle cycle");

  // a run only finishes on its last character
  a_run_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_char_o |-> busy_o)
    else $error("idle in the middle of a run");

  // only a minus sign or a digit, and the run never ends on the sign
  a_char_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (ascii_char_o == CH_MINUS && !last_char_o) ||
                (ascii_char_o >= CH_ZERO && ascii_char_o <= CH_ZERO + 6'd9))
    else $error("bad character");

endmodule

bind signed_int_to_decimal_ascii sid_checker u_sid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .valid_o     (valid_o),
  .ascii_char_o(ascii_char_o),
  .last_char_o (last_char_o)
);
